[sv/http_request_header_parser_macros.svh]
// Assertion macros shared by the parser RTL.
// Define ASSERT_OFF to compile every assertion away.
`ifndef HTTP_REQUEST_HEADER_PARSER_MACROS_SVH
`define HTTP_REQUEST_HEADER_PARSER_MACROS_SVH

`ifndef ASSERT_OFF
// Concurrent check, sampled on the rising clock, switched off while reset is low.
`define HRP_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);
// Concurrent check that also holds while reset is asserted.
`define HRP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define HRP_ASSERT(lbl, clk, rst_n, prop, msg)
`define HRP_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

[sv/hrp_pkg.sv]
`default_nettype none

package hrp_pkg;

  // Default width of the version accumulators.
  localparam int unsigned HRP_VERSION_BITS = 16;

  // Status reported for every consumed byte.
  typedef enum logic [1:0] {
    STATUS_MORE = 2'd0,
    STATUS_GOOD = 2'd1,
    STATUS_BAD  = 2'd2
  } status_e;

  // Role tag attached to each echoed byte.
  typedef enum logic [2:0] {
    ROLE_NONE   = 3'd0,
    ROLE_METHOD = 3'd1,
    ROLE_URI    = 3'd2,
    ROLE_NAME   = 3'd3,
    ROLE_VALUE  = 3'd4
  } role_e;

  // Input item opcodes.
  localparam logic OP_BYTE  = 1'b0;
  localparam logic OP_RESET = 1'b1;

  // Input item.
  typedef struct packed {
    logic       op;
    logic [7:0] data_byte;
  } hrp_in_t;

  // Result item.
  typedef struct packed {
    status_e     status;
    role_e       byte_role;
    logic        new_header;
    logic [7:0]  out_byte;
    logic [15:0] version_major;
    logic [15:0] version_minor;
  } hrp_out_t;

  // Character codes used by the grammar.
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_H     = 8'h48;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_DEL   = 8'h7F;
  localparam logic [7:0] CH_LAST_CTL = 8'h1F;

  // Control characters: 0 to 31 and DEL. Bytes above 127 are not controls.
  function automatic logic is_control(input logic [7:0] b);
    return (b <= CH_LAST_CTL) || (b == CH_DEL);
  endfunction

  // Separator characters of the token grammar.
  function automatic logic is_special(input logic [7:0] b);
    logic r;
    case (b) inside
      8'h28, 8'h29, 8'h3C, 8'h3E, 8'h40, 8'h2C, 8'h3B, 8'h3A, 8'h5C, 8'h22,
      8'h2F, 8'h5B, 8'h5D, 8'h3F, 8'h3D, 8'h7B, 8'h7D, 8'h20, 8'h09: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  // Token characters: 7-bit, not a control, not a separator.
  function automatic logic is_token(input logic [7:0] b);
    return !b[7] && !is_control(b) && !is_special(b);
  endfunction

  // Decimal digit.
  function automatic logic is_dec(input logic [7:0] b);
    return (b >= 8'h30) && (b <= 8'h39);
  endfunction

endpackage

`default_nettype wire

[sv/hrp_stream_if.sv]
`default_nettype none

// Valid/ready channel carrying one item of type T.
interface hrp_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[sv/http_request_header_parser.sv]
// Channel | Dir | Item                               | Handshake
// in_i    | in  | op, data_byte                      | valid/ready
// out_o   | out | status, byte_role, new_header,     | valid/ready
//         |     | out_byte, version_major/minor      |
//
// One byte per clock while the output is not stalled: an accepted item sits in the
// input register, the state machine parses it there, and its result is registered
// in the result register when the item advances.
// A stalled output holds its result; the input stage still takes one more item.
// rst_ni clears the parser to method start and empties both stages.
`default_nettype none

`include "http_request_header_parser_macros.svh"

module http_request_header_parser
  import hrp_pkg::*;
#(
  parameter int unsigned VERSION_BITS = HRP_VERSION_BITS
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  hrp_stream_if.sink   in_i,
  hrp_stream_if.source out_o
);

  // Parser states, one-hot.
  typedef enum logic [21:0] {
    ST_METHOD_START = 22'h000001,
    ST_METHOD       = 22'h000002,
    ST_URI          = 22'h000004,
    ST_VER_H        = 22'h000008,
    ST_VER_T1       = 22'h000010,
    ST_VER_T2       = 22'h000020,
    ST_VER_P        = 22'h000040,
    ST_VER_SLASH    = 22'h000080,
    ST_MAJOR_START  = 22'h000100,
    ST_MAJOR        = 22'h000200,
    ST_MINOR_START  = 22'h000400,
    ST_MINOR        = 22'h000800,
    ST_NL1          = 22'h001000,
    ST_LINE_START   = 22'h002000,
    ST_LWS          = 22'h004000,
    ST_NAME         = 22'h008000,
    ST_SP_VALUE     = 22'h010000,
    ST_VALUE        = 22'h020000,
    ST_NL2          = 22'h040000,
    ST_NL3          = 22'h080000,
    ST_GOOD         = 22'h100000,
    ST_BAD          = 22'h200000
  } state_e;

  localparam int unsigned VB = VERSION_BITS;

  // Multiply by ten, add a digit, saturate at the accumulator maximum.
  function automatic logic [VB-1:0] acc_digit(input logic [VB-1:0] acc,
                                              input logic [3:0]    digit);
    logic [VB+3:0] wide;
    logic [VB+3:0] sum;
    wide = {4'b0000, acc};
    sum  = (wide << 3) + (wide << 1) + {{VB{1'b0}}, digit};
    return (|sum[VB+3:VB]) ? {VB{1'b1}} : sum[VB-1:0];
  endfunction

  // Pipeline registers.
  logic     in_valid_q;
  hrp_in_t  in_q;
  logic     out_valid_q;
  hrp_out_t out_q;
  hrp_out_t res_d;
  logic     advance;

  // Parser state.
  state_e        state_q, state_d;
  logic          seen_q, seen_d;
  logic [VB-1:0] major_q, major_d;
  logic [VB-1:0] minor_q, minor_d;

  // The registered item moves on when the result slot is free or being emptied.
  assign advance    = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || advance;

  // Input stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.valid && in_i.ready) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_q <= in_i.data;
    end
  end

  // Next-state and result logic for the registered byte.
  always_comb begin
    logic [7:0] b;
    logic [3:0] digit;
    status_e    status;
    role_e      role;
    logic       nh;
    b       = in_q.data_byte;
    digit   = b[3:0];
    status  = STATUS_MORE;
    role    = ROLE_NONE;
    nh      = 1'b0;
    state_d = state_q;
    seen_d  = seen_q;
    major_d = major_q;
    minor_d = minor_q;

    unique case (state_q)
      ST_METHOD_START: begin
        if (is_token(b)) begin
          state_d = ST_METHOD;
          role    = ROLE_METHOD;
        end else status = STATUS_BAD;
      end
      ST_METHOD: begin
        if (b == CH_SPACE) state_d = ST_URI;
        else if (is_token(b)) role = ROLE_METHOD;
        else status = STATUS_BAD;
      end
      ST_URI: begin
        if (b == CH_SPACE) state_d = ST_VER_H;
        else if (is_control(b)) status = STATUS_BAD;
        else role = ROLE_URI;
      end
      ST_VER_H: begin
        if (b == CH_H) state_d = ST_VER_T1; else status = STATUS_BAD;
      end
      ST_VER_T1: begin
        if (b == CH_T) state_d = ST_VER_T2; else status = STATUS_BAD;
      end
      ST_VER_T2: begin
        if (b == CH_T) state_d = ST_VER_P; else status = STATUS_BAD;
      end
      ST_VER_P: begin
        if (b == CH_P) state_d = ST_VER_SLASH; else status = STATUS_BAD;
      end
      ST_VER_SLASH: begin
        if (b == CH_SLASH) begin
          major_d = '0;
          minor_d = '0;
          state_d = ST_MAJOR_START;
        end else status = STATUS_BAD;
      end
      ST_MAJOR_START: begin
        if (is_dec(b)) begin
          major_d = acc_digit(major_q, digit);
          state_d = ST_MAJOR;
        end else status = STATUS_BAD;
      end
      ST_MAJOR: begin
        if (b == CH_DOT) state_d = ST_MINOR_START;
        else if (is_dec(b)) major_d = acc_digit(major_q, digit);
        else status = STATUS_BAD;
      end
      ST_MINOR_START: begin
        if (is_dec(b)) begin
          minor_d = acc_digit(minor_q, digit);
          state_d = ST_MINOR;
        end else status = STATUS_BAD;
      end
      ST_MINOR: begin
        if (b == CH_CR) state_d = ST_NL1;
        else if (is_dec(b)) minor_d = acc_digit(minor_q, digit);
        else status = STATUS_BAD;
      end
      ST_NL1, ST_NL2: begin
        if (b == CH_LF) state_d = ST_LINE_START; else status = STATUS_BAD;
      end
      ST_LINE_START: begin
        if (b == CH_CR) state_d = ST_NL3;
        else if (seen_q && (b == CH_SPACE || b == CH_TAB)) state_d = ST_LWS;
        else if (is_token(b)) begin
          seen_d  = 1'b1;
          role    = ROLE_NAME;
          nh      = 1'b1;
          state_d = ST_NAME;
        end else status = STATUS_BAD;
      end
      ST_LWS: begin
        if (b == CH_CR) state_d = ST_NL2;
        else if (b == CH_SPACE || b == CH_TAB) state_d = ST_LWS;
        else if (is_control(b)) status = STATUS_BAD;
        else begin
          role    = ROLE_VALUE;
          state_d = ST_VALUE;
        end
      end
      ST_NAME: begin
        if (b == CH_COLON) state_d = ST_SP_VALUE;
        else if (is_token(b)) role = ROLE_NAME;
        else status = STATUS_BAD;
      end
      ST_SP_VALUE: begin
        if (b == CH_SPACE) state_d = ST_VALUE; else status = STATUS_BAD;
      end
      ST_VALUE: begin
        if (b == CH_CR) state_d = ST_NL2;
        else if (is_control(b)) status = STATUS_BAD;
        else role = ROLE_VALUE;
      end
      ST_NL3: begin
        status = (b == CH_LF) ? STATUS_GOOD : STATUS_BAD;
      end
      ST_GOOD: begin
        status = STATUS_GOOD;
      end
      default: begin
        status = STATUS_BAD;
      end
    endcase

    if (status == STATUS_GOOD) state_d = ST_GOOD;
    else if (status == STATUS_BAD) state_d = ST_BAD;

    res_d.status        = status;
    res_d.byte_role     = role;
    res_d.new_header    = nh;
    res_d.out_byte      = b;
    res_d.version_major = 16'(major_d);
    res_d.version_minor = 16'(minor_d);

    // A reset item returns the parser to method start and answers all zeros.
    if (in_q.op == OP_RESET) begin
      state_d = ST_METHOD_START;
      seen_d  = 1'b0;
      major_d = '0;
      minor_d = '0;
      res_d   = '0;
    end
  end

  // Parser state update.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_METHOD_START;
      seen_q  <= 1'b0;
      major_q <= '0;
      minor_q <= '0;
    end else if (advance) begin
      state_q <= state_d;
      seen_q  <= seen_d;
      major_q <= major_d;
      minor_q <= minor_d;
    end
  end

  // Result stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= res_d;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  // The state register always holds exactly one state.
  `HRP_ASSERT(a_state_onehot, clk_i, rst_ni, $onehot(state_q),
              "parser state is not one-hot")

  // Only the first byte of a header name is flagged as a new header.
  `HRP_ASSERT(a_new_header_role, clk_i, rst_ni,
              !out_valid_q || !out_q.new_header || out_q.byte_role == ROLE_NAME,
              "new_header set on a byte that is not a header name")

  // A finished status never carries a tagged byte.
  `HRP_ASSERT(a_done_untagged, clk_i, rst_ni,
              !out_valid_q || out_q.status == STATUS_MORE ||
              (out_q.byte_role == ROLE_NONE && !out_q.new_header),
              "complete or malformed result carries a role")

  // A finished parse stays finished until a reset item.
  `HRP_ASSERT(a_good_sticks, clk_i, rst_ni,
              (advance && in_q.op == OP_BYTE && state_q == ST_GOOD) |=>
              (state_q == ST_GOOD),
              "complete state left without a reset item")

  // A new item is never taken while the input stage is full and stalled.
  `HRP_ASSERT(a_no_overrun, clk_i, rst_ni,
              (in_i.valid && in_i.ready) |-> (!in_valid_q || advance),
              "input stage overwritten while holding an item")

endmodule

`default_nettype wire
